// File: rtl/core/rwsp_pkg.sv
// rwsp_pkg: shared types, codes and constants of the riff/wave stream parser
// no dependencies
`timescale 1ns / 1ps
package rwsp_pkg;

   localparam int CountWidthDefault = 32;
   localparam int RiffHeaderBytes   = 12;
   localparam int PcmFormatBytes    = 16;

   localparam logic [31:0] TagRiff = 32'h52494646;
   localparam logic [31:0] TagWave = 32'h57415645;
   localparam logic [31:0] TagFmt  = 32'h666d7420;
   localparam logic [31:0] TagData = 32'h64617461;
   localparam logic [15:0] FormatPcm        = 16'h0001;
   localparam logic [15:0] FormatExtensible = 16'hfffe;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_SHORT   = 4'd1,
      ST_TAGS    = 4'd2,
      ST_OVERRUN = 4'd3,
      ST_SHORTFMT= 4'd4,
      ST_NOFMT   = 4'd5,
      ST_NODATA  = 4'd6,
      ST_NOTPCM  = 4'd7,
      ST_BITS    = 4'd8,
      ST_ZERO    = 4'd9,
      ST_PARTIAL = 4'd10
   } status_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic        chunk_start;
      logic [3:0]  status;
      logic [15:0] format_tag;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] kept_bytes;
   } rsp_type;

   // entry handed from the parser to the result unit for each data byte and for the last byte
   typedef struct packed {
      logic        has_data;
      logic [7:0]  data_byte;
      logic        chunk_start;
      logic        is_last;
      logic [3:0]  pre_status;
      logic        need_trim;
      logic [15:0] format_tag;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] data_length;
   } work_type;

endpackage

// File: rtl/core/riff_wave_stream_parser.sv
// channel | direction | handshake
// req_    | in        | req_valid / req_ready, req_data (file_byte, is_last)
// rsp_    | out       | rsp_valid / rsp_ready, rsp_data (data or status)
// the parser takes one byte per cycle while the queue has room; the result unit
// accepts a data byte, then outputs it, and takes no new entry until it is output
// the final status is accepted, passes through the bit-serial frame divider when the
// length is trimmed, and is then output
// reset is synchronous; the block returns to its reset state after each last byte
// a two-entry queue lets the parser run while results wait for rsp_ready
`timescale 1ns / 1ps
module riff_wave_stream_parser #(
   parameter int COUNT_WIDTH = rwsp_pkg::CountWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwsp_pkg::rsp_type rsp_data
);
   import rwsp_pkg::*;

   work_type f_data, b_data;
   logic     f_valid, f_ready, b_valid, b_ready;

   rwsp_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .wq_valid(f_valid), .wq_ready(f_ready), .wq_data(f_data)
   );

   rwsp_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   rwsp_back u_back (
      .clock, .reset, .wq_valid(b_valid), .wq_ready(b_ready), .wq_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// File: rtl/core/rwsp_front.sv
// rwsp_front: byte parser, one byte per cycle while the queue has room, emits work entries
// depends on rwsp_pkg
`timescale 1ns / 1ps
module rwsp_front #(
   parameter int COUNT_WIDTH = rwsp_pkg::CountWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rwsp_pkg::req_type  req_data,
   output logic               wq_valid,
   input  logic               wq_ready,
   output rwsp_pkg::work_type wq_data
);
   import rwsp_pkg::*;

   typedef enum logic [4:0] {
      PH_RIFF = 5'b00001,
      PH_HEAD = 5'b00010,
      PH_BODY = 5'b00100,
      PH_PAD  = 5'b01000,
      PH_STOP = 5'b10000
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] PosMax = '1;

   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  pos_ff, pos_in;
   logic [63:0]             hdr_ff, hdr_in;
   logic [31:0]             remain_ff, remain_in;
   logic                    is_fmt_ff, is_fmt_in, is_data_ff, is_data_in;
   logic [4:0]              fidx_ff, fidx_in;
   logic [15:0]             tag_ff, tag_in, chan_ff, chan_in, bits_ff, bits_in;
   logic [31:0]             rate_ff, rate_in, dlen_ff, dlen_in;
   logic                    seen_ff, seen_in, sfmt_ff, sfmt_in;
   logic [3:0]              err_ff, err_in;

   logic        go;
   logic [7:0]  b;
   logic [63:0] sh;
   logic [31:0] size;
   logic        emit_data, start_flag;
   logic [3:0]  pre;

   assign req_ready = wq_ready;
   assign go        = req_valid && req_ready;
   assign b         = req_data.file_byte;
   assign sh        = {hdr_ff[55:0], b};
   assign size      = {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};

   // per-byte parse step
   always_comb begin
      phase_in = phase_ff;  hdr_in = hdr_ff;  remain_in = remain_ff;
      is_fmt_in = is_fmt_ff; is_data_in = is_data_ff; fidx_in = fidx_ff;
      tag_in = tag_ff; chan_in = chan_ff; rate_in = rate_ff; bits_in = bits_ff;
      seen_in = seen_ff; dlen_in = dlen_ff; sfmt_in = sfmt_ff; err_in = err_ff;
      emit_data = 1'b0;
      start_flag = 1'b0;
      unique case (phase_ff)
         PH_RIFF: begin
            hdr_in = sh;
            if (pos_ff == COUNT_WIDTH'(3) && sh[31:0] != TagRiff) err_in = ST_TAGS;
            if (pos_ff == COUNT_WIDTH'(RiffHeaderBytes - 1)) begin
               if (sh[31:0] != TagWave) err_in = ST_TAGS;
               phase_in = (err_in != ST_OK) ? PH_STOP : PH_HEAD;
               hdr_in = '0;
               fidx_in = '0;
            end
         end
         PH_HEAD: begin
            hdr_in = sh;
            fidx_in = fidx_ff + 5'd1;
            if (fidx_ff >= 5'd7) begin
               fidx_in = '0;
               remain_in = size;
               is_fmt_in = 1'b0;
               is_data_in = 1'b0;
               if (sh[63:32] == TagFmt) begin
                  is_fmt_in = 1'b1;
                  seen_in = 1'b1;
                  if (size < 32'(PcmFormatBytes)) sfmt_in = 1'b1;
               end else if (sh[63:32] == TagData) begin
                  is_data_in = 1'b1;
                  dlen_in = size;
               end
               if (size == '0) begin
                  if (sfmt_in) begin
                     err_in = ST_SHORTFMT;
                     phase_in = PH_STOP;
                  end else phase_in = PH_HEAD;
               end else phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (is_fmt_ff && fidx_ff < 5'(PcmFormatBytes)) begin
               case (fidx_ff)
                  5'd0:  tag_in[7:0]    = b;
                  5'd1:  tag_in[15:8]   = b;
                  5'd2:  chan_in[7:0]   = b;
                  5'd3:  chan_in[15:8]  = b;
                  5'd4:  rate_in[7:0]   = b;
                  5'd5:  rate_in[15:8]  = b;
                  5'd6:  rate_in[23:16] = b;
                  5'd7:  rate_in[31:24] = b;
                  5'd14: bits_in[7:0]   = b;
                  5'd15: bits_in[15:8]  = b;
                  default: ;
               endcase
               fidx_in = fidx_ff + 5'd1;
            end else if (is_data_ff) begin
               emit_data = 1'b1;
               start_flag = (remain_ff == dlen_ff);
            end
            remain_in = remain_ff - 32'd1;
            if (remain_in == '0) begin
               fidx_in = '0;
               if (sfmt_ff) begin
                  err_in = ST_SHORTFMT;
                  phase_in = PH_STOP;
               end else if (hdr_ff[24]) phase_in = PH_PAD;
               else phase_in = PH_HEAD;
            end
         end
         PH_PAD: begin
            phase_in = PH_HEAD;
            fidx_in = '0;
         end
         PH_STOP: ;
         default: phase_in = PH_STOP;
      endcase
      pos_in = (pos_ff < PosMax) ? pos_ff + COUNT_WIDTH'(1) : pos_ff;
   end

   // status check that needs no divide
   always_comb begin
      if (pos_in < COUNT_WIDTH'(RiffHeaderBytes))           pre = ST_SHORT;
      else if (err_in != ST_OK)                             pre = err_in;
      else if (phase_in == PH_BODY && remain_in != '0)      pre = ST_OVERRUN;
      else if (!seen_in)                                    pre = ST_NOFMT;
      else if (dlen_in == '0)                               pre = ST_NODATA;
      else if (tag_in != FormatPcm && tag_in != FormatExtensible) pre = ST_NOTPCM;
      else if (bits_in != 16'd16 && bits_in != 16'd8)       pre = ST_BITS;
      else if (chan_in == '0 || rate_in == '0)              pre = ST_ZERO;
      else                                                  pre = ST_OK;
   end

   // queue entry
   always_comb begin
      wq_valid = go && (emit_data || req_data.is_last);
      wq_data.has_data        = emit_data;
      wq_data.data_byte       = b;
      wq_data.chunk_start     = start_flag;
      wq_data.is_last         = req_data.is_last;
      wq_data.pre_status      = pre;
      wq_data.need_trim       = (pre == ST_OK);
      wq_data.format_tag      = tag_in;
      wq_data.channels        = chan_in;
      wq_data.sample_rate     = rate_in;
      wq_data.bits_per_sample = bits_in;
      wq_data.data_length     = dlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (go && req_data.is_last)) begin
         phase_ff <= PH_RIFF; pos_ff <= '0; hdr_ff <= '0; remain_ff <= '0;
         is_fmt_ff <= 1'b0; is_data_ff <= 1'b0; fidx_ff <= '0;
         tag_ff <= '0; chan_ff <= '0; rate_ff <= '0; bits_ff <= '0;
         seen_ff <= 1'b0; dlen_ff <= '0; sfmt_ff <= 1'b0; err_ff <= ST_OK;
      end else if (go) begin
         phase_ff <= phase_in; pos_ff <= pos_in; hdr_ff <= hdr_in;
         remain_ff <= remain_in; is_fmt_ff <= is_fmt_in; is_data_ff <= is_data_in;
         fidx_ff <= fidx_in; tag_ff <= tag_in; chan_ff <= chan_in;
         rate_ff <= rate_in; bits_ff <= bits_in; seen_ff <= seen_in;
         dlen_ff <= dlen_in; sfmt_ff <= sfmt_in; err_ff <= err_in;
      end
   end
endmodule

// File: rtl/core/rwsp_queue.sv
// rwsp_queue: two-entry fifo between parser and result unit
// depends on rwsp_pkg
`timescale 1ns / 1ps
module rwsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rwsp_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rwsp_pkg::work_type out_data
);
   import rwsp_pkg::*;

   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule

// File: rtl/core/rwsp_back.sv
// rwsp_back: emits data and status results, trims length to whole frames
// depends on rwsp_pkg
`timescale 1ns / 1ps
module rwsp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               wq_valid,
   output logic               wq_ready,
   input  rwsp_pkg::work_type wq_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rwsp_pkg::rsp_type  rsp_data
);
   import rwsp_pkg::*;

   typedef enum logic [3:0] {
      BK_IDLE = 4'b0001,
      BK_DATA = 4'b0010,
      BK_DIV  = 4'b0100,
      BK_STAT = 4'b1000
   } back_type;

   back_type    st_ff, st_in;
   work_type    w_ff;
   logic [31:0] rem_ff, quo_ff;
   logic [19:0] frame_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] trial;
   logic [51:0] prod;
   logic        tail_ok;
   logic [3:0]  fstat;

   assign trial = {rem_ff, quo_ff[31]} - {13'd0, frame_ff};
   assign prod  = {20'd0, quo_ff} * {32'd0, frame_ff};

   // fsm
   always_comb begin
      st_in = st_ff;
      wq_ready = 1'b0;
      unique case (st_ff)
         BK_IDLE: begin
            wq_ready = 1'b1;
            if (wq_valid) st_in = wq_data.has_data ? BK_DATA :
                                  (wq_data.need_trim ? BK_DIV : BK_STAT);
         end
         BK_DATA: if (rsp_ready)
            st_in = !w_ff.is_last ? BK_IDLE : (w_ff.need_trim ? BK_DIV : BK_STAT);
         BK_DIV:  if (cnt_ff == 6'd32) st_in = BK_STAT;
         BK_STAT: if (rsp_ready) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= BK_IDLE;
      else       st_ff <= st_in;
   end

   // restoring divide, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (st_ff == BK_IDLE && wq_valid) begin
         w_ff     <= wq_data;
         rem_ff   <= '0;
         quo_ff   <= wq_data.data_length;
         frame_ff <= 20'(wq_data.channels) * 20'(wq_data.bits_per_sample[4:3]);
         cnt_ff   <= '0;
      end else if (st_ff == BK_DIV && cnt_ff != 6'd32) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   assign tail_ok = (quo_ff != '0);
   assign fstat = !w_ff.need_trim ? w_ff.pre_status : (tail_ok ? ST_OK : ST_PARTIAL);

   // result mux
   always_comb begin
      rsp_valid = (st_ff == BK_DATA) || (st_ff == BK_STAT);
      rsp_data = '0;
      if (st_ff == BK_DATA) begin
         rsp_data.data_byte   = w_ff.data_byte;
         rsp_data.chunk_start = w_ff.chunk_start;
      end else begin
         rsp_data.kind   = 1'b1;
         rsp_data.status = fstat;
         if (fstat == ST_OK || fstat >= ST_NOTPCM) begin
            rsp_data.format_tag      = w_ff.format_tag;
            rsp_data.channels        = w_ff.channels;
            rsp_data.sample_rate     = w_ff.sample_rate;
            rsp_data.bits_per_sample = w_ff.bits_per_sample;
         end
         if (fstat == ST_OK) rsp_data.kept_bytes = prod[31:0];
      end
   end
endmodule
